@@ rtl/bbra_pkg.sv @@
// Package for the bounded byte RAM: sizes, operation codes, controller/datapath structs.
// No dependencies; imported by the controller, datapath and top level.
`timescale 1ns / 1ps
`default_nettype none

package bbra_pkg;

  // Bytes of RAM behind the block
  localparam int unsigned MEM_BYTES = 65536;
  localparam int unsigned ADDR_W    = $clog2(MEM_BYTES);
  // RAM is split into eight byte lanes; a row holds one byte of each lane
  localparam int unsigned LANES     = 8;
  localparam int unsigned ROW_W     = ADDR_W - 3;
  localparam int unsigned ROWS      = (MEM_BYTES + 7) / 8;

  // Width of the size register and of fill lengths
  localparam int unsigned SIZE_W    = 17;
  localparam int unsigned POS_W     = SIZE_W + 1;
  localparam logic [SIZE_W-1:0] MEM_SIZE_RESET = 17'h10000;
  localparam logic [7:0] BYTE_MASK  = 8'hFF;

  typedef enum logic [1:0] {
    OP_READ  = 2'd0,
    OP_WRITE = 2'd1,
    OP_FILL  = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  // Controller -> datapath
  typedef struct packed {
    logic load;      // capture a new item
    logic clear_wr;  // clear one row after reset
    logic fill_wr;   // zero the in-range bytes of one row
    logic mem_wr;    // byte-lane write of the item
    logic set_res;   // update result registers
    logic res_read;  // result carries read data
  } ctrl_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    op_e  op;
    logic ok;          // range check passed
    logic fill_empty;  // zero-length fill
    logic fill_last;   // current row is the last row of the fill
    logic clear_last;  // current row is the last row of the RAM
  } ctrl_stat_t;

  // Bound used by all checks: mem_size saturated to the RAM size
  function automatic logic [SIZE_W-1:0] active_size(input logic [SIZE_W-1:0] m);
    if (32'(m) > MEM_BYTES) begin
      return SIZE_W'(MEM_BYTES);
    end
    return m;
  endfunction

endpackage

`default_nettype wire

@@ rtl/bbra_ram.sv @@
// Generic single-port RAM, one write or read per cycle, registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module bbra_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] addr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

@@ rtl/bbra_ctrl.sv @@
// Controller FSM of the bounded byte RAM: clear pass, check, read wait, fill sweep.
// Depends on bbra_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bbra_ctrl
  import bbra_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       start,
  output logic            busy,
  output logic            done_o,
  input  wire ctrl_stat_t stat_i,
  output ctrl_cmd_t       cmd_o
);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CHECK,
    ST_READ,
    ST_FILL
  } state_e;

  state_e state_q, state_d;
  logic   done_q, done_d;

  always_comb begin
    state_d = state_q;
    done_d  = 1'b0;
    cmd_o   = '0;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clear_wr = 1'b1;
        if (stat_i.clear_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          cmd_o.load = 1'b1;
          state_d    = ST_CHECK;
        end
      end
      ST_CHECK: begin
        // default: finish now with fault or plain zero result
        cmd_o.set_res = 1'b1;
        done_d        = 1'b1;
        state_d       = ST_IDLE;
        case (stat_i.op)
          OP_READ: begin
            if (stat_i.ok) begin
              cmd_o.set_res = 1'b0;
              done_d        = 1'b0;
              state_d       = ST_READ;
            end
          end
          OP_WRITE: begin
            cmd_o.mem_wr = stat_i.ok;
          end
          OP_FILL: begin
            if (stat_i.ok && !stat_i.fill_empty) begin
              cmd_o.set_res = 1'b0;
              done_d        = 1'b0;
              state_d       = ST_FILL;
            end
          end
          default: begin
          end
        endcase
      end
      ST_READ: begin
        cmd_o.set_res  = 1'b1;
        cmd_o.res_read = 1'b1;
        done_d         = 1'b1;
        state_d        = ST_IDLE;
      end
      ST_FILL: begin
        cmd_o.fill_wr = 1'b1;
        if (stat_i.fill_last) begin
          cmd_o.set_res = 1'b1;
          done_d        = 1'b1;
          state_d       = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  assign busy   = (state_q != ST_IDLE);
  assign done_o = done_q;

endmodule

`default_nettype wire

@@ rtl/bbra_dp.sv @@
// Datapath of the bounded byte RAM: operand and size registers, range check,
// eight byte-lane RAMs with lane steering, row counter, result registers.
// Depends on bbra_pkg and bbra_ram.
`timescale 1ns / 1ps
`default_nettype none

module bbra_dp
  import bbra_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire ctrl_cmd_t         cmd_i,
  output ctrl_stat_t             stat_o,
  input  wire logic [1:0]        operation_i,
  input  wire logic [1:0]        access_size_i,
  input  wire logic [63:0]       address_i,
  input  wire logic [63:0]       write_data_i,
  input  wire logic [SIZE_W-1:0] fill_length_i,
  input  wire logic              cfg_we_i,
  input  wire logic [SIZE_W-1:0] cfg_wdata_i,
  output logic [63:0]            read_data_o,
  output logic                   fault_o
);

  // Operands of the current item
  op_e               op_q;
  logic [1:0]        size_q;
  logic [63:0]       addr_q;
  logic [63:0]       wdata_q;
  logic [SIZE_W-1:0] flen_q;

  logic [SIZE_W-1:0] mem_size_q;
  logic [ROW_W-1:0]  row_q, row_d;
  logic [63:0]       rdata_q;
  logic              fault_q;

  // Range check
  logic [SIZE_W-1:0] act_size, rem, len;
  logic [3:0]        nbytes;
  logic              addr_ok, range_ok;
  logic [POS_W-1:0]  start_pos, end_pos, last_pos;
  logic [2:0]        off;
  logic [ROW_W-1:0]  row0;

  // Lane signals
  logic [LANES-1:0]  bank_we;
  logic [ROW_W-1:0]  bank_addr  [LANES];
  logic [7:0]        bank_wdata [LANES];
  logic [7:0]        bank_rdata [LANES];
  logic [63:0]       rd_word;

  assign nbytes   = 4'd1 << size_q;
  assign act_size = active_size(mem_size_q);
  assign addr_ok  = (addr_q[63:SIZE_W] == '0) && (addr_q[SIZE_W-1:0] <= act_size);
  assign rem      = act_size - addr_q[SIZE_W-1:0];
  assign len      = (op_q == OP_FILL) ? flen_q : SIZE_W'(nbytes);
  assign range_ok = addr_ok && (len <= rem);

  assign start_pos = {1'b0, addr_q[SIZE_W-1:0]};
  assign end_pos   = start_pos + {1'b0, flen_q};
  assign last_pos  = end_pos - POS_W'(1);
  assign off       = addr_q[2:0];
  assign row0      = addr_q[ADDR_W-1:3];

  always_comb begin
    stat_o            = '0;
    stat_o.op         = op_q;
    stat_o.ok         = range_ok;
    stat_o.fill_empty = (flen_q == '0);
    stat_o.fill_last  = (row_q == ROW_W'(last_pos >> 3));
    stat_o.clear_last = (row_q == ROW_W'(ROWS - 1));
  end

  // Lane steering: byte i of the item sits in lane (off + i) mod 8; lanes below
  // the start offset belong to the next row.
  always_comb begin
    logic [2:0]       lane;
    logic [POS_W-1:0] pos;
    logic             fill_en;
    logic             wr_en;
    for (int b = 0; b < LANES; b++) begin
      lane    = 3'(b) - off;
      pos     = POS_W'({row_q, 3'(b)});
      fill_en = (pos >= start_pos) && (pos < end_pos);
      wr_en   = ({1'b0, lane} < nbytes);
      bank_we[b]    = cmd_i.clear_wr | (cmd_i.fill_wr & fill_en) | (cmd_i.mem_wr & wr_en);
      bank_addr[b]  = (cmd_i.clear_wr | cmd_i.fill_wr) ? row_q
                                                       : row0 + ROW_W'(3'(b) < off);
      bank_wdata[b] = cmd_i.mem_wr ? (wdata_q[{lane, 3'b000} +: 8] & BYTE_MASK) : 8'h00;
    end
  end

  always_comb begin
    logic [2:0] lane;
    rd_word = '0;
    for (int i = 0; i < LANES; i++) begin
      lane = 3'(i) + off;
      if (4'(i) < nbytes) begin
        rd_word[8*i +: 8] = bank_rdata[lane];
      end
    end
  end

  for (genvar g = 0; g < LANES; g++) begin : g_lane
    bbra_ram #(
      .WIDTH(8),
      .DEPTH(ROWS)
    ) u_ram (
      .clk_i  (clk_i),
      .we_i   (bank_we[g]),
      .addr_i (bank_addr[g]),
      .wdata_i(bank_wdata[g]),
      .rdata_o(bank_rdata[g])
    );
  end

  always_comb begin
    row_d = row_q;
    if (cmd_i.load) begin
      row_d = address_i[ADDR_W-1:3];
    end else if (cmd_i.clear_wr || cmd_i.fill_wr) begin
      row_d = row_q + ROW_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mem_size_q <= MEM_SIZE_RESET;
      row_q      <= '0;
    end else begin
      row_q <= row_d;
      if (cfg_we_i) begin
        mem_size_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q    <= op_e'(operation_i);
      size_q  <= access_size_i;
      addr_q  <= address_i;
      wdata_q <= write_data_i;
      flen_q  <= fill_length_i;
    end
    if (cmd_i.set_res) begin
      rdata_q <= cmd_i.res_read ? rd_word : 64'd0;
      fault_q <= !cmd_i.res_read && (op_q != OP_NONE) && !range_ok;
    end
  end

  assign read_data_o = rdata_q;
  assign fault_o     = fault_q;

endmodule

`default_nettype wire

@@ rtl/bounded_byte_ram_access.sv @@
// Top level of the bounded byte RAM: controller plus datapath.
// Depends on bbra_pkg, bbra_ctrl, bbra_dp (and bbra_ram below it).
//
// Usage:
//  - Command channel: an item (operation, access_size, address, write_data,
//    fill_length) is taken at a rising edge with start high and busy low.
//  - Result channel: read_data_o and fault_o are valid while done_o is high,
//    which is for exactly one cycle. The receiver cannot stall; the outputs
//    hold only until the next result is set. busy drops in the same cycle
//    done_o rises, so the next item may be issued while a result is shown.
//  - Configuration: cfg_we_i writes cfg_wdata_i into mem_size, the bound for
//    all checks (saturated to MEM_BYTES). Write only while idle.
//  - Sequence from accept to done_o: a write, a faulting or an unused op
//    finishes in the check state; a read adds a read state (registered lane
//    RAM read); a zero fill adds a sweep over the rows it touches, where a
//    row is 8 bytes, one row per cycle. One item at a time.
//  - Storage: eight byte-wide lane RAMs, row = address / 8, so any 1..8 byte
//    access at any alignment is one access per lane.
//  - Reset: mem_size goes to 65536 and a clearing pass zeroes the RAM one
//    row per cycle, all MEM_BYTES / 8 rows (8192 for 64 KiB); busy is high
//    throughout. Configuration writes are taken during the pass.
`timescale 1ns / 1ps
`default_nettype none

module bounded_byte_ram_access
  import bbra_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  // command channel
  input  wire logic              start,
  output logic                   busy,
  input  wire logic [1:0]        operation_i,
  input  wire logic [1:0]        access_size_i,
  input  wire logic [63:0]       address_i,
  input  wire logic [63:0]       write_data_i,
  input  wire logic [SIZE_W-1:0] fill_length_i,
  // configuration
  input  wire logic              cfg_we_i,
  input  wire logic [SIZE_W-1:0] cfg_wdata_i,
  // result channel
  output logic                   done_o,
  output logic [63:0]            read_data_o,
  output logic                   fault_o
);

  ctrl_cmd_t  cmd;
  ctrl_stat_t stat;

  // sequencing: clear pass, check, read wait, fill sweep
  bbra_ctrl u_ctrl (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .start (start),
    .busy  (busy),
    .done_o(done_o),
    .stat_i(stat),
    .cmd_o (cmd)
  );

  // operands, range check, lane RAMs, results
  bbra_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .operation_i  (operation_i),
    .access_size_i(access_size_i),
    .address_i    (address_i),
    .write_data_i (write_data_i),
    .fill_length_i(fill_length_i),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .read_data_o  (read_data_o),
    .fault_o      (fault_o)
  );

endmodule

`default_nettype wire
